### rtl/core/pwvr_pkg.sv
// Package: word types, op and status codes, and phase encoding for the wire value reader.
package pwvr_pkg;

	localparam int unsigned POS_BITS = 32;

	typedef logic [POS_BITS-1:0] pos_t;

	localparam logic [3:0] OP_V8      = 4'd0;
	localparam logic [3:0] OP_V32     = 4'd1;
	localparam logic [3:0] OP_V64     = 4'd2;
	localparam logic [3:0] OP_SV32    = 4'd3;
	localparam logic [3:0] OP_SV64    = 4'd4;
	localparam logic [3:0] OP_F32     = 4'd5;
	localparam logic [3:0] OP_F64     = 4'd6;
	localparam logic [3:0] OP_LEN     = 4'd7;
	localparam logic [3:0] OP_SKIPVAR = 4'd8;
	localparam logic [3:0] OP_SKIPN   = 4'd9;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNDERRUN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [6:0] LIMIT_W32 = 7'd31;
	localparam logic [6:0] LIMIT_W64 = 7'd63;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_VARINT,
		PH_FIXED,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [31:0] skip_count;
	} in_word_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic [3:0]  kind;
		logic [31:0] payload_start;
	} out_word_t;

endpackage

### rtl/core/pwvr_in_stage.sv
// Input register stage of the wire value reader.
module pwvr_in_stage import pwvr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  in_word_t byte_word,
	input  logic     take,
	output logic     valid_s1,
	output in_word_t item_s1
);

	assign byte_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_word;
		end
	end

endmodule

### rtl/core/pwvr_decode.sv
// Decode state and single-pass decode logic for one buffer byte.
module pwvr_decode import pwvr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_word_t  item,
	output logic      emit,
	output out_word_t result
);

	phase_t      phase_q, ph;
	logic [3:0]  kind_q, kd;
	logic [63:0] acc_q, acc;
	logic [6:0]  shift_q, sh;
	logic [31:0] left_q, bl;
	pos_t        pos_q, pos_d;

	logic [63:0] e_val;
	logic [1:0]  e_st;
	pos_t        e_start;
	logic        more;
	logic        w32;

	assign more  = item.data_byte[7];
	assign pos_d = item.last_byte ? '0 : pos_q + pos_t'(1);

	always_comb begin
		ph      = phase_q;
		kd      = kind_q;
		acc     = acc_q;
		sh      = shift_q;
		bl      = left_q;
		w32     = 1'b0;
		emit    = 1'b0;
		e_val   = '0;
		e_st    = ST_OK;
		e_start = '0;
		if (phase_q == PH_IDLE) begin
			acc = '0;
			sh  = '0;
			bl  = '0;
			if (item.op <= OP_SKIPN) begin
				kd = item.op;
				case (item.op)
					OP_F32: begin
						ph = PH_FIXED;
						bl = 32'd4;
					end
					OP_F64: begin
						ph = PH_FIXED;
						bl = 32'd8;
					end
					OP_SKIPN: begin
						ph = PH_SKIP;
						bl = (item.skip_count == '0) ? 32'd1 : item.skip_count;
					end
					default: begin
						ph = PH_VARINT;
					end
				endcase
			end
		end
		w32 = (kd == OP_V32) || (kd == OP_SV32) || (kd == OP_LEN);
		case (ph)
			PH_VARINT: begin
				if (kd == OP_V8) begin
					emit = 1'b1;
					if (more) begin
						e_st = ST_OVERFLOW;
					end else begin
						e_val = {56'd0, item.data_byte};
					end
				end else if (kd == OP_SKIPVAR) begin
					emit = !more;
				end else begin
					if (!sh[6]) begin
						acc = acc | ({57'd0, item.data_byte[6:0]} << sh[5:0]);
					end
					if (w32) begin
						acc[63:32] = '0;
					end
					sh = sh + 7'd7;
					if (more && (sh > (w32 ? LIMIT_W32 : LIMIT_W64))) begin
						emit = 1'b1;
						e_st = ST_OVERFLOW;
					end else if (!more) begin
						case (kd)
							OP_SV32: begin
								emit  = 1'b1;
								e_val = {32'd0, {1'b0, acc[31:1]} ^ {32{acc[0]}}};
							end
							OP_SV64: begin
								emit  = 1'b1;
								e_val = {1'b0, acc[63:1]} ^ {64{acc[0]}};
							end
							OP_LEN: begin
								if (acc == '0) begin
									emit    = 1'b1;
									e_start = pos_q + pos_t'(1);
								end else begin
									ph = PH_SKIP;
									bl = acc[31:0];
								end
							end
							default: begin
								emit  = 1'b1;
								e_val = acc;
							end
						endcase
					end
				end
			end
			PH_FIXED: begin
				if (!sh[6]) begin
					acc = acc | ({56'd0, item.data_byte} << sh[5:0]);
				end
				sh = sh + 7'd8;
				if (bl != '0) begin
					bl = bl - 32'd1;
				end
				if (bl == '0) begin
					emit  = 1'b1;
					e_val = acc;
				end
			end
			PH_SKIP: begin
				if (bl != '0) begin
					bl = bl - 32'd1;
				end
				if (bl == '0) begin
					emit = 1'b1;
					if (kd == OP_LEN) begin
						e_val   = acc;
						e_start = pos_q + pos_t'(1) - pos_t'(acc);
					end
				end
			end
			default: begin
			end
		endcase
		if (!emit && item.last_byte && (ph != PH_IDLE)) begin
			emit    = 1'b1;
			e_st    = ST_UNDERRUN;
			e_val   = '0;
			e_start = '0;
		end
		if (emit) begin
			ph = PH_IDLE;
		end
	end

	always_comb begin
		result.value         = e_val;
		result.status        = e_st;
		result.kind          = kd;
		result.payload_start = 32'(e_start);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= '0;
			acc_q   <= '0;
			shift_q <= '0;
			left_q  <= '0;
			pos_q   <= '0;
		end else if (fire) begin
			phase_q <= ph;
			kind_q  <= kd;
			acc_q   <= acc;
			shift_q <= sh;
			left_q  <= bl;
			pos_q   <= pos_d;
		end
	end

endmodule

### rtl/core/pwvr_out_reg.sv
// Result register of the wire value reader.
module pwvr_out_reg import pwvr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  logic      emit,
	input  out_word_t result,
	output logic      take,
	output logic      result_valid,
	input  logic      result_ready,
	output out_word_t result_word
);

	logic      valid_s2;
	out_word_t word_s2;

	assign take         = !valid_s2 || result_ready;
	assign result_valid = valid_s2;
	assign result_word  = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= emit;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			word_s2 <= result;
		end
	end

endmodule

### rtl/core/protobuf_wire_value_reader.sv
// Top level of the protocol-buffer wire value reader.
//
// byte_valid/byte_ready/byte_word carry one buffer byte per word; while idle
// the word's op starts a value (and skip_count for a byte skip). Each word
// gives zero or one result on result_valid/result_ready/result_word:
// the decoded value, or length and payload offset, with status and kind.
// One word is taken every cycle unless the receiver stalls. A word accepted
// sits in the input register and its result, if any, is registered in the
// result register when the word is passed on to the decoder.
// The decode state (phase, accumulator, shift, byte count, buffer offset)
// updates once per word in a single pass of logic between the two registers.
// When the receiver stalls with a result waiting, the result register and
// the decode state hold and byte_ready drops until the result is taken; an
// empty input register can still take one word meanwhile. Reset clears the
// valid bits of both registers, idles the decoder and zeroes the buffer offset.
module protobuf_wire_value_reader import pwvr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_ready,
	input  in_word_t  byte_word,
	output logic      result_valid,
	input  logic      result_ready,
	output out_word_t result_word
);

	logic      take;
	logic      valid_s1;
	in_word_t  item_s1;
	logic      fire;
	logic      emit;
	out_word_t result;

	assign fire = valid_s1 && take;

	pwvr_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_word  (byte_word),
		.take       (take),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	pwvr_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.emit   (emit),
		.result (result)
	);

	pwvr_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.emit         (emit),
		.result       (result),
		.take         (take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

endmodule
